>>> rtl/lbfs_pkg.sv
// ----------------------------------------------------------------------------
// lbfs_pkg
// Shared types and constants of the LED breathing fade sequencer: mode
// codes, configuration register map, reset values and interface structs.
// ----------------------------------------------------------------------------
package lbfs_pkg;

  // Widths
  localparam int unsigned LevelW  = 8;
  localparam int unsigned TickW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 8;

  // Sequencer mode, also the phase output code
  typedef enum logic [2:0] {
    ModeOff      = 3'd0,
    ModeRise     = 3'd1,
    ModeHoldHigh = 3'd2,
    ModeFall     = 3'd3,
    ModeHoldLow  = 3'd4
  } mode_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegLevelMax  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLevelMin  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStepUp    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStepDown  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHoldHigh  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegHoldLow   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegEnable    = 3'd6;

  // Reset values of the registers
  localparam logic [LevelW-1:0] LevelMaxRst = 8'hff;
  localparam logic [LevelW-1:0] LevelMinRst = 8'h00;
  localparam logic [LevelW-1:0] StepUpRst   = 8'h01;
  localparam logic [LevelW-1:0] StepDownRst = 8'h01;
  localparam logic [TickW-1:0]  HoldHighRst = 8'hff;
  localparam logic [TickW-1:0]  HoldLowRst  = 8'h8f;

  // Saturation bounds
  localparam logic [LevelW-1:0] LevelFull  = 8'hff;
  localparam logic [LevelW-1:0] LevelEmpty = 8'h00;

  // Configuration bundle
  typedef struct packed {
    logic [LevelW-1:0] level_max;
    logic [LevelW-1:0] level_min;
    logic [LevelW-1:0] step_up;
    logic [LevelW-1:0] step_down;
    logic [TickW-1:0]  hold_high_ticks;
    logic [TickW-1:0]  hold_low_ticks;
    logic              enable;
  } cfg_t;

  // Sequencer state
  typedef struct packed {
    mode_e             mode;
    logic [LevelW-1:0] brightness;
    logic [TickW-1:0]  tick_count;
  } seq_state_t;

  // Result of one tick
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              level_written;
    mode_e             phase;
  } tick_res_t;

endpackage

>>> rtl/led_breathe_fade_sequencer_top.sv
// ----------------------------------------------------------------------------
// led_breathe_fade_sequencer_top
// LED breathing fade sequencer: one tick in, one brightness result out.
// ----------------------------------------------------------------------------
// Each accepted tick produces exactly one result. A tick enters an input
// register, the tick logic runs combinationally against the sequencer state,
// and the result lands in an output register, from which it is taken when
// the output is not stalled. One tick is taken every cycle while the output
// is not stalled, the rate being set by the state update loop. The input
// stalls only while both registers are full and the output is stalled.
// Configuration writes are always accepted and must be made while no tick
// is in flight.
module led_breathe_fade_sequencer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tick input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          night_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lbfs_pkg::LevelW-1:0]   level_o,
  output logic                          level_written_o,
  output logic [2:0]                    phase_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lbfs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lbfs_pkg::CfgDatW-1:0]  cfg_data_i
);

  lbfs_pkg::cfg_t       cfg;
  lbfs_pkg::seq_state_t state_q, state_d;
  lbfs_pkg::tick_res_t  res_d, res_q;
  logic                 in_vld_q, night_q;
  logic                 out_vld_q;
  logic                 in_acc, s1_adv;

  lbfs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lbfs_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .night_i (night_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Handshake: input stage moves on when the output register is empty or its result is being taken
  assign s1_adv     = in_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = in_vld_q & out_vld_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q           <= 1'b0;
      out_vld_q          <= 1'b0;
      state_q.mode       <= lbfs_pkg::ModeOff;
      state_q.brightness <= '0;
      state_q.tick_count <= '0;
    end else begin
      if (in_acc)      in_vld_q <= 1'b1;
      else if (s1_adv) in_vld_q <= 1'b0;
      if (s1_adv) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) night_q <= night_i;
    if (s1_adv) res_q   <= res_d;
  end

  assign out_valid_o     = out_vld_q;
  assign level_o         = res_q.level;
  assign level_written_o = res_q.level_written;
  assign phase_o         = res_q.phase;

endmodule

>>> rtl/lbfs_cfg_regs.sv
// ----------------------------------------------------------------------------
// lbfs_cfg_regs
// Configuration register file. One write per transaction, indexes beyond
// the map are dropped. Always ready.
// ----------------------------------------------------------------------------
module lbfs_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lbfs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [lbfs_pkg::CfgDatW-1:0]      cfg_data_i,
  output lbfs_pkg::cfg_t                    cfg_o
);

  lbfs_pkg::cfg_t cfg_q;
  logic           wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;
  assign cfg_o       = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_max       <= lbfs_pkg::LevelMaxRst;
      cfg_q.level_min       <= lbfs_pkg::LevelMinRst;
      cfg_q.step_up         <= lbfs_pkg::StepUpRst;
      cfg_q.step_down       <= lbfs_pkg::StepDownRst;
      cfg_q.hold_high_ticks <= lbfs_pkg::HoldHighRst;
      cfg_q.hold_low_ticks  <= lbfs_pkg::HoldLowRst;
      cfg_q.enable          <= 1'b0;
    end else if (wr_en) begin
      case (cfg_index_i)
        lbfs_pkg::RegLevelMax: cfg_q.level_max       <= cfg_data_i;
        lbfs_pkg::RegLevelMin: cfg_q.level_min       <= cfg_data_i;
        lbfs_pkg::RegStepUp:   cfg_q.step_up         <= cfg_data_i;
        lbfs_pkg::RegStepDown: cfg_q.step_down       <= cfg_data_i;
        lbfs_pkg::RegHoldHigh: cfg_q.hold_high_ticks <= cfg_data_i;
        lbfs_pkg::RegHoldLow:  cfg_q.hold_low_ticks  <= cfg_data_i;
        lbfs_pkg::RegEnable:   cfg_q.enable          <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/lbfs_step.sv
// ----------------------------------------------------------------------------
// lbfs_step
// Next-state logic of one tick: count, clamp, then the five mode checks in
// order so transitions can cascade within the tick.
// ----------------------------------------------------------------------------
module lbfs_step (
  input  lbfs_pkg::cfg_t       cfg_i,
  input  lbfs_pkg::seq_state_t state_i,
  input  logic                 night_i,
  output lbfs_pkg::seq_state_t state_o,
  output lbfs_pkg::tick_res_t  res_o
);

  always_comb begin
    logic [lbfs_pkg::LevelW:0]   sum;
    logic [lbfs_pkg::LevelW-1:0] b;
    logic [lbfs_pkg::TickW-1:0]  cnt;
    lbfs_pkg::mode_e             m;
    logic                        wrote;

    sum   = '0;
    cnt   = state_i.tick_count + 8'd1;
    m     = state_i.mode;
    wrote = 1'b0;

    // Clamp: upper limit first, lower limit wins if the two cross
    b = state_i.brightness;
    if (b > cfg_i.level_max) b = cfg_i.level_max;
    if (b < cfg_i.level_min) b = cfg_i.level_min;

    // Off: start a cycle at night when enabled
    if (m == lbfs_pkg::ModeOff) begin
      if (night_i && cfg_i.enable) begin
        cnt = '0;
        m   = lbfs_pkg::ModeRise;
      end
    end

    // Rise: saturating add
    if (m == lbfs_pkg::ModeRise) begin
      sum   = {1'b0, b} + {1'b0, cfg_i.step_up};
      b     = sum[lbfs_pkg::LevelW] ? lbfs_pkg::LevelFull : sum[lbfs_pkg::LevelW-1:0];
      wrote = 1'b1;
      if (b >= cfg_i.level_max) begin
        m   = lbfs_pkg::ModeHoldHigh;
        cnt = '0;
      end
    end

    // Hold high
    if (m == lbfs_pkg::ModeHoldHigh) begin
      if (cnt >= cfg_i.hold_high_ticks) m = lbfs_pkg::ModeFall;
    end

    // Fall: saturating subtract
    if (m == lbfs_pkg::ModeFall) begin
      b     = (cfg_i.step_down <= b) ? (b - cfg_i.step_down) : lbfs_pkg::LevelEmpty;
      wrote = 1'b1;
      if (b <= cfg_i.level_min) begin
        m   = lbfs_pkg::ModeHoldLow;
        cnt = '0;
      end
    end

    // Hold low
    if (m == lbfs_pkg::ModeHoldLow) begin
      if (cnt >= cfg_i.hold_low_ticks) m = lbfs_pkg::ModeOff;
    end

    state_o.mode          = m;
    state_o.brightness    = b;
    state_o.tick_count    = cnt;
    res_o.level           = b;
    res_o.level_written   = wrote;
    res_o.phase           = m;
  end

endmodule

>>> rtl/lbfs_checker.sv
// ----------------------------------------------------------------------------
// lbfs_checker
// Port-level checks of the sequencer top, bound to every instance.
// ----------------------------------------------------------------------------
module lbfs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [lbfs_pkg::LevelW-1:0]   level_o,
  input logic                          level_written_o,
  input logic [2:0]                    phase_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(level_o)
      && $stable(level_written_o) && $stable(phase_o))
    else $error("stalled result changed");

  // Ending a tick in rise or fall means a step ran
  a_step_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (phase_o == lbfs_pkg::ModeRise || phase_o == lbfs_pkg::ModeFall)
      |-> level_written_o)
    else $error("rise or fall without level write");

  // Input stalls only behind a stalled, full output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

bind led_breathe_fade_sequencer_top lbfs_checker u_lbfs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .level_o         (level_o),
  .level_written_o (level_written_o),
  .phase_o         (phase_o)
);

>>> verif/tb_led_breathe_fade_sequencer_top.sv
// ----------------------------------------------------------------------------
// tb_led_breathe_fade_sequencer_top
// Self-checking bench for the LED breathing fade sequencer. A directed table
// covers reset behavior, the saturation limits, zero steps and zero holds,
// a full cascade in one tick, minimum above maximum and the unused register
// index. Random phases follow; each reprograms every register and then sends
// bursts of night ticks. Every result transaction is compared with a typed
// expectation or with a cycle-free model of the mode machine kept in the bench.
// ----------------------------------------------------------------------------
module tb_led_breathe_fade_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it
  localparam logic [lbfs_pkg::CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int unsigned RandomTicks = 500;

  typedef enum logic {
    OpTick,
    OpWrite
  } plan_op_e;

  typedef struct packed {
    plan_op_e                       op;
    logic [lbfs_pkg::CfgIdxW-1:0]   reg_idx;
    logic [lbfs_pkg::CfgDatW-1:0]   data;
    logic                           night;
    logic                           checked;
    lbfs_pkg::tick_res_t            want;
  } plan_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic                           night_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [lbfs_pkg::LevelW-1:0]    level_o;
  logic                           level_written_o;
  logic [2:0]                     phase_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [lbfs_pkg::CfgIdxW-1:0]   cfg_index_i = '0;
  logic [lbfs_pkg::CfgDatW-1:0]   cfg_data_i = '0;

  // Model of the sequencer
  lbfs_pkg::cfg_t                 fade_cfg;
  lbfs_pkg::mode_e                fade_mode;
  logic [lbfs_pkg::LevelW-1:0]    fade_level;
  logic [lbfs_pkg::TickW-1:0]     fade_ticks;

  lbfs_pkg::tick_res_t            due_tick_results[$];
  int unsigned                    ticks_sent;
  int unsigned                    results_checked;
  int unsigned                    mismatch_count;
  logic                           send_idle = 1'b1;
  logic                           recv_idle = 1'b1;

  // Directed plan: expected results typed in where obvious, else modeled
  plan_row_t directed_plan [35] = '{
    '{OpTick,  '0, 8'h00, 1'b0, 1'b1, '{8'd0,   1'b0, lbfs_pkg::ModeOff}},
    '{OpTick,  '0, 8'h00, 1'b1, 1'b1, '{8'd0,   1'b0, lbfs_pkg::ModeOff}},
    '{OpWrite, lbfs_pkg::RegStepUp,   8'hff, 1'b0, 1'b0, '0},
    '{OpWrite, lbfs_pkg::RegEnable,   8'hff, 1'b0, 1'b0, '0},
    '{OpTick,  '0, 8'h00, 1'b1, 1'b1, '{8'd255, 1'b1, lbfs_pkg::ModeHoldHigh}},
    '{OpWrite, lbfs_pkg::RegHoldHigh, 8'h00, 1'b0, 1'b0, '0},
    '{OpTick,  '0, 8'h00, 1'b0, 1'b1, '{8'd254, 1'b1, lbfs_pkg::ModeFall}},
    '{OpWrite, lbfs_pkg::RegStepDown, 8'hff, 1'b0, 1'b0, '0},
    '{OpTick,  '0, 8'h00, 1'b0, 1'b1, '{8'd0,   1'b1, lbfs_pkg::ModeHoldLow}},
    '{OpWrite, lbfs_pkg::RegHoldLow,  8'h00, 1'b0, 1'b0, '0},
    '{OpTick,  '0, 8'h00, 1'b0, 1'b1, '{8'd0,   1'b0, lbfs_pkg::ModeOff}},
    // zero holds and full steps: off to off within one tick
    '{OpTick,  '0, 8'h00, 1'b1, 1'b1, '{8'd0,   1'b1, lbfs_pkg::ModeOff}},
    '{OpWrite, RegUnused,             8'ha5, 1'b0, 1'b0, '0},
    '{OpTick,  '0, 8'h00, 1'b1, 1'b1, '{8'd0,   1'b1, lbfs_pkg::ModeOff}},
    // minimum above maximum
    '{OpWrite, lbfs_pkg::RegLevelMax, 8'h0a, 1'b0, 1'b0, '0},
    '{OpWrite, lbfs_pkg::RegLevelMin, 8'h14, 1'b0, 1'b0, '0},
    '{OpTick,  '0, 8'h00, 1'b0, 1'b1, '{8'd20,  1'b0, lbfs_pkg::ModeOff}},
    '{OpTick,  '0, 8'h00, 1'b1, 1'b0, '0},
    // zero rising step
    '{OpWrite, lbfs_pkg::RegStepUp,   8'h00, 1'b0, 1'b0, '0},
    '{OpWrite, lbfs_pkg::RegLevelMin, 8'h00, 1'b0, 1'b0, '0},
    '{OpWrite, lbfs_pkg::RegLevelMax, 8'hff, 1'b0, 1'b0, '0},
    '{OpTick,  '0, 8'h00, 1'b1, 1'b1, '{8'd0,   1'b1, lbfs_pkg::ModeRise}},
    '{OpTick,  '0, 8'h00, 1'b0, 1'b0, '0},
    '{OpWrite, lbfs_pkg::RegStepUp,   8'hff, 1'b0, 1'b0, '0},
    '{OpTick,  '0, 8'h00, 1'b1, 1'b0, '0},
    // short holds, mid-size steps
    '{OpWrite, lbfs_pkg::RegHoldHigh, 8'h03, 1'b0, 1'b0, '0},
    '{OpWrite, lbfs_pkg::RegHoldLow,  8'h02, 1'b0, 1'b0, '0},
    '{OpWrite, lbfs_pkg::RegStepUp,   8'h40, 1'b0, 1'b0, '0},
    '{OpWrite, lbfs_pkg::RegStepDown, 8'h30, 1'b0, 1'b0, '0},
    '{OpTick,  '0, 8'h00, 1'b1, 1'b0, '0},
    '{OpTick,  '0, 8'h00, 1'b1, 1'b0, '0},
    '{OpTick,  '0, 8'h00, 1'b1, 1'b0, '0},
    '{OpTick,  '0, 8'h00, 1'b1, 1'b0, '0},
    '{OpTick,  '0, 8'h00, 1'b1, 1'b0, '0},
    '{OpTick,  '0, 8'h00, 1'b1, 1'b0, '0}
  };

  led_breathe_fade_sequencer_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .night_i         (night_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .level_o         (level_o),
    .level_written_o (level_written_o),
    .phase_o         (phase_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", results_checked, msg);
    mismatch_count++;
  endtask

  // One tick of the sequencer: clamp, then the mode checks in order
  function automatic lbfs_pkg::tick_res_t advance_fade(input logic night);
    lbfs_pkg::tick_res_t          res;
    logic                         wrote;
    logic [lbfs_pkg::LevelW:0]    wide;
    wrote = 1'b0;
    fade_ticks = fade_ticks + 1'b1;
    if (fade_level > fade_cfg.level_max) fade_level = fade_cfg.level_max;
    if (fade_level < fade_cfg.level_min) fade_level = fade_cfg.level_min;
    if (fade_mode == lbfs_pkg::ModeOff && night && fade_cfg.enable) begin
      fade_ticks = '0;
      fade_mode  = lbfs_pkg::ModeRise;
    end
    if (fade_mode == lbfs_pkg::ModeRise) begin
      wide = {1'b0, fade_level} + {1'b0, fade_cfg.step_up};
      fade_level = wide[lbfs_pkg::LevelW] ? lbfs_pkg::LevelFull
                                          : wide[lbfs_pkg::LevelW-1:0];
      wrote = 1'b1;
      if (fade_level >= fade_cfg.level_max) begin
        fade_mode  = lbfs_pkg::ModeHoldHigh;
        fade_ticks = '0;
      end
    end
    if (fade_mode == lbfs_pkg::ModeHoldHigh && fade_ticks >= fade_cfg.hold_high_ticks) begin
      fade_mode = lbfs_pkg::ModeFall;
    end
    if (fade_mode == lbfs_pkg::ModeFall) begin
      // borrow out of bit 8 means the step went below zero
      wide = {1'b0, fade_level} - {1'b0, fade_cfg.step_down};
      fade_level = wide[lbfs_pkg::LevelW] ? lbfs_pkg::LevelEmpty
                                          : wide[lbfs_pkg::LevelW-1:0];
      wrote = 1'b1;
      if (fade_level <= fade_cfg.level_min) begin
        fade_mode  = lbfs_pkg::ModeHoldLow;
        fade_ticks = '0;
      end
    end
    if (fade_mode == lbfs_pkg::ModeHoldLow && fade_ticks >= fade_cfg.hold_low_ticks) begin
      fade_mode = lbfs_pkg::ModeOff;
    end
    res.level         = fade_level;
    res.level_written = wrote;
    res.phase         = fade_mode;
    return res;
  endfunction

  // Send one tick transaction; queue the typed result or the modeled one
  task automatic send_tick(input logic night, input logic checked,
                           input lbfs_pkg::tick_res_t want);
    lbfs_pkg::tick_res_t modeled;
    int unsigned         gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    night_i    <= night;
    do @(posedge clk_i); while (in_stall_o);
    modeled = advance_fade(night);
    due_tick_results.push_back(checked ? want : modeled);
    ticks_sent++;
  endtask

  // Wait until every result is back so the block sits idle
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (due_tick_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [lbfs_pkg::CfgIdxW-1:0] idx,
                           input logic [lbfs_pkg::CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      lbfs_pkg::RegLevelMax: fade_cfg.level_max       = data;
      lbfs_pkg::RegLevelMin: fade_cfg.level_min       = data;
      lbfs_pkg::RegStepUp:   fade_cfg.step_up         = data;
      lbfs_pkg::RegStepDown: fade_cfg.step_down       = data;
      lbfs_pkg::RegHoldHigh: fade_cfg.hold_high_ticks = data;
      lbfs_pkg::RegHoldLow:  fade_cfg.hold_low_ticks  = data;
      lbfs_pkg::RegEnable:   fade_cfg.enable          = data[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Result side: random stall before each transaction
  initial begin
    int unsigned hold;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = recv_idle ? $urandom_range(0, 8) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    lbfs_pkg::tick_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_tick_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result level %0d phase %0d",
                                  level_o, phase_o));
      end else begin
        want = due_tick_results.pop_front();
        if (level_o !== want.level)
          report_mismatch($sformatf("level %0d, want %0d", level_o, want.level));
        if (level_written_o !== want.level_written)
          report_mismatch($sformatf("level_written %0b, want %0b",
                                    level_written_o, want.level_written));
        if (phase_o !== want.phase)
          report_mismatch($sformatf("phase %0d, want %0d", phase_o, want.phase));
      end
      results_checked++;
    end
  end

  // Stimulus
  initial begin
    logic [lbfs_pkg::CfgDatW-1:0] value;
    int unsigned                  burst;
    fade_cfg   = '{lbfs_pkg::LevelMaxRst, lbfs_pkg::LevelMinRst,
                   lbfs_pkg::StepUpRst, lbfs_pkg::StepDownRst,
                   lbfs_pkg::HoldHighRst, lbfs_pkg::HoldLowRst, 1'b0};
    fade_mode  = lbfs_pkg::ModeOff;
    fade_level = '0;
    fade_ticks = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_plan[i]) begin
      if (directed_plan[i].op == OpWrite) begin
        settle_block();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].data);
      end else begin
        send_tick(directed_plan[i].night, directed_plan[i].checked,
                  directed_plan[i].want);
      end
    end

    // random phases: reprogram everything, then a burst of ticks
    ticks_sent = 0;
    while (ticks_sent < RandomTicks) begin
      settle_block();
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      for (int r = 0; r < 8; r++) begin
        case (r[lbfs_pkg::CfgIdxW-1:0])
          lbfs_pkg::RegLevelMax: begin
            case ($urandom_range(0, 5))
              0:       value = lbfs_pkg::LevelEmpty;
              1:       value = lbfs_pkg::LevelFull;
              default: value = 8'($urandom_range(128, 255));
            endcase
          end
          lbfs_pkg::RegLevelMin: begin
            case ($urandom_range(0, 5))
              0:       value = lbfs_pkg::LevelEmpty;
              1:       value = lbfs_pkg::LevelFull;
              default: value = 8'($urandom_range(0, 127));
            endcase
          end
          lbfs_pkg::RegStepUp, lbfs_pkg::RegStepDown: begin
            case ($urandom_range(0, 9))
              0:       value = lbfs_pkg::LevelEmpty;
              1:       value = lbfs_pkg::LevelFull;
              default: value = 8'($urandom_range(1, 48));
            endcase
          end
          lbfs_pkg::RegHoldHigh, lbfs_pkg::RegHoldLow: begin
            case ($urandom_range(0, 7))
              0:       value = 8'h00;
              1:       value = 8'hff;
              default: value = 8'($urandom_range(0, 12));
            endcase
          end
          lbfs_pkg::RegEnable: begin
            // upper bits are don't-care; bit 0 mostly set
            value = 8'($urandom_range(0, 255));
            value[0] = $urandom_range(0, 5) != 0;
          end
          default: value = 8'($urandom_range(0, 255));
        endcase
        if (r[lbfs_pkg::CfgIdxW-1:0] != RegUnused || $urandom_range(0, 3) == 0)
          write_reg(r[lbfs_pkg::CfgIdxW-1:0], value);
      end
      burst = $urandom_range(20, 60);
      repeat (burst) send_tick($urandom_range(0, 4) != 0, 1'b0, '0);
    end

    settle_block();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
